// ===== rtl/core/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg: shared types, constants and tables of the sRGB 2x2 box downsampler
// Holds the pixel and queue entry structures, the configuration register codes
// and the two colour tables, which are computed once at elaboration.
// ----------------------------------------------------------------------------
package sbd_pkg;

   localparam int MaxWidth      = 4096;
   localparam int MaxHeight     = 16384;
   localparam int WidthRegBits  = 13;
   localparam int HeightRegBits = 15;
   localparam int CsrDataBits   = 15;
   localparam int CsrIndexBits  = 2;
   localparam int ColBits       = $clog2(MaxWidth);
   localparam int RowBits       = $clog2(MaxHeight);
   localparam int StoreDepth    = MaxWidth / 2;
   localparam int StoreAddrBits = $clog2(StoreDepth);

   localparam int ColorLanes    = 3;
   localparam int ByteBits      = 8;
   localparam int TabDepth      = 1 << ByteBits;
   localparam int LinBits       = 16;
   localparam int PairBits      = LinBits + 1;
   localparam int TotBits       = LinBits + 2;
   localparam int AlphaPairBits = ByteBits + 1;
   localparam int AlphaTotBits  = ByteBits + 2;
   localparam int StoreBits     = ColorLanes * PairBits + AlphaPairBits;
   localparam int IndexBits     = 12;
   localparam int ThrBits       = 14;
   localparam int SearchSteps   = ByteBits;

   localparam int QueueDepth     = 4;
   localparam int QueuePtrBits   = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_MODE   = 2'd2
   } csr_index_type;

   // What the back end does with a horizontal pair.
   typedef enum logic [1:0] {
      KIND_STORE,
      KIND_DOUBLE,
      KIND_COMBINE
   } kind_type;

   typedef struct packed {
      logic [ByteBits-1:0] red_in;
      logic [ByteBits-1:0] green_in;
      logic [ByteBits-1:0] blue_in;
      logic [ByteBits-1:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [ByteBits-1:0] red_out;
      logic [ByteBits-1:0] green_out;
      logic [ByteBits-1:0] blue_out;
      logic [ByteBits-1:0] alpha_out;
      logic                level_done;
   } rsp_type;

   typedef struct packed {
      logic [WidthRegBits-1:0]  width;
      logic [HeightRegBits-1:0] height;
      logic                     color_mode;
      logic                     restart;
   } cfg_type;

   typedef struct packed {
      kind_type                               kind;
      logic [StoreAddrBits-1:0]               addr;
      logic [ColorLanes-1:0][PairBits-1:0]    pair_color;
      logic [AlphaPairBits-1:0]               pair_alpha;
      logic                                   color_mode;
      logic                                   level_done;
   } entry_type;

   // sRGB decode in unsigned Q2.30, argument n/510 with n in 0..510.
   localparam longint unsigned DecodeDenom = 510;
   localparam longint unsigned LinearDiv   = DecodeDenom * 1292;
   localparam longint unsigned PowerDiv    = DecodeDenom * 1055;
   localparam longint unsigned OneQ30      = 64'd1 << 30;

   function automatic longint unsigned mul_q30(input longint unsigned a,
                                               input longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned fifth_root_q30(input longint unsigned w);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned sq;
      longint unsigned p;
      lo = 0;
      hi = OneQ30;
      for (int it = 0; it < 32; it++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            sq  = mul_q30(mid, mid);
            p   = mul_q30(mul_q30(sq, sq), mid);
            if (p <= w) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
      end
      return lo;
   endfunction

   function automatic longint unsigned decode_q30(input longint unsigned n);
      longint unsigned y;
      longint unsigned w;
      if (n * 100000 <= 4045 * DecodeDenom) begin
         return ((n << 30) * 100) / LinearDiv;
      end
      y = ((1000 * n + 55 * DecodeDenom) << 30) / PowerDiv;
      if (y > OneQ30) begin
         y = OneQ30;
      end
      w = mul_q30(y, y);
      return mul_q30(w, fifth_root_q30(w));
   endfunction

   typedef logic [TabDepth-1:0][LinBits-1:0] lin_tab_type;
   typedef logic [TabDepth-1:0][ThrBits-1:0] thr_tab_type;

   // sRGB byte to linear Q0.16, rounded and saturated.
   function automatic lin_tab_type build_lin_tab();
      lin_tab_type     t;
      longint unsigned v;
      for (int c = 0; c < TabDepth; c++) begin
         v = (decode_q30(64'(2 * c)) + 8192) >> 14;
         t[c] = (v > 65535) ? {LinBits{1'b1}} : LinBits'(v);
      end
      return t;
   endfunction

   // Decision thresholds of the encoder, expressed in units of 2^17 (Q30)
   // and rounded up, so that a byte b is reached when its entry is at most
   // the odd representative 2i+1 of a 12-bit mean index i.
   function automatic thr_tab_type build_thr_tab();
      thr_tab_type     t;
      longint unsigned v;
      t[0] = '0;
      for (int b = 1; b < TabDepth; b++) begin
         v = (decode_q30(64'(2 * b - 1)) + 131071) >> 17;
         t[b] = ThrBits'(v);
      end
      return t;
   endfunction

   localparam lin_tab_type LinTab = build_lin_tab();
   localparam thr_tab_type ThrTab = build_thr_tab();

endpackage

// ===== rtl/core/sbd_ram.sv =====
// ----------------------------------------------------------------------------
// sbd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/sbd_front.sv =====
// ----------------------------------------------------------------------------
// sbd_front: pixel intake and pair classification
// Converts each source pixel, forms horizontal pairs and tells the back end
// whether a pair is to be stored, doubled or combined with the row above.
// ----------------------------------------------------------------------------
module sbd_front (
   input  logic                clock,
   input  logic                reset,
   input  sbd_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  sbd_pkg::req_type    req_pixel,
   input  logic                queue_full,
   output logic                push,
   output sbd_pkg::entry_type  push_entry
);

   logic accept;
   logic width_one;
   logic height_one;
   logic col_last;
   logic row_last;
   logic paired;
   logic push_wanted;
   logic hold_we;
   sbd_pkg::kind_type push_kind;

   logic [sbd_pkg::ColBits-1:0] col_ff;
   logic [sbd_pkg::ColBits-1:0] col_in;
   logic [sbd_pkg::RowBits-1:0] row_ff;
   logic [sbd_pkg::RowBits-1:0] row_in;

   logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::ByteBits-1:0] color_byte;
   logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::LinBits-1:0]  conv;
   logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::LinBits-1:0]  hold_color_ff;
   logic [sbd_pkg::ByteBits-1:0]                          hold_alpha_ff;
   logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::PairBits-1:0] pair_color;
   logic [sbd_pkg::AlphaPairBits-1:0]                     pair_alpha;

   logic [sbd_pkg::WidthRegBits-1:0]  last_col_pair;
   logic [sbd_pkg::HeightRegBits-1:0] last_row_pair;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign width_one  = (cfg.width == sbd_pkg::WidthRegBits'(1));
   assign height_one = (cfg.height == sbd_pkg::HeightRegBits'(1));
   assign col_last   = (sbd_pkg::WidthRegBits'(col_ff) + sbd_pkg::WidthRegBits'(1))
                       >= cfg.width;
   assign row_last   = (sbd_pkg::HeightRegBits'(row_ff) + sbd_pkg::HeightRegBits'(1))
                       >= cfg.height;

   assign color_byte = {req_pixel.blue_in, req_pixel.green_in, req_pixel.red_in};

   always_comb begin
      for (int j = 0; j < sbd_pkg::ColorLanes; j++) begin
         conv[j] = cfg.color_mode ? sbd_pkg::LinTab[color_byte[j]]
                                  : sbd_pkg::LinBits'(color_byte[j]);
         pair_color[j] = width_one ? {conv[j], 1'b0}
                       : sbd_pkg::PairBits'(hold_color_ff[j])
                         + sbd_pkg::PairBits'(conv[j]);
      end
      pair_alpha = width_one ? {req_pixel.alpha_in, 1'b0}
                 : sbd_pkg::AlphaPairBits'(hold_alpha_ff)
                   + sbd_pkg::AlphaPairBits'(req_pixel.alpha_in);
   end

   // A narrow image pairs each pixel with itself.
   assign paired  = width_one || col_ff[0];
   assign hold_we = accept && !width_one && !col_ff[0] && !col_last;

   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_color_ff <= conv;
         hold_alpha_ff <= req_pixel.alpha_in;
      end
   end

   // The trailing row of an odd height is dropped.
   always_comb begin
      push_kind   = sbd_pkg::KIND_STORE;
      push_wanted = 1'b0;
      priority if (height_one) begin
         push_kind   = sbd_pkg::KIND_DOUBLE;
         push_wanted = 1'b1;
      end else if (!row_ff[0]) begin
         push_kind   = sbd_pkg::KIND_STORE;
         push_wanted = !row_last;
      end else begin
         push_kind   = sbd_pkg::KIND_COMBINE;
         push_wanted = 1'b1;
      end
   end

   assign last_col_pair = width_one ? '0
                        : (cfg.width >> 1) - sbd_pkg::WidthRegBits'(1);
   assign last_row_pair = height_one ? '0
                        : (cfg.height >> 1) - sbd_pkg::HeightRegBits'(1);

   assign push = accept && paired && push_wanted;

   always_comb begin
      push_entry.kind       = push_kind;
      push_entry.addr       = sbd_pkg::StoreAddrBits'(col_ff >> 1);
      push_entry.pair_color = pair_color;
      push_entry.pair_alpha = pair_alpha;
      push_entry.color_mode = cfg.color_mode;
      push_entry.level_done =
         (sbd_pkg::HeightRegBits'(row_ff >> 1) == last_row_pair) &&
         (sbd_pkg::WidthRegBits'(col_ff >> 1) == last_col_pair);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/core/sbd_queue.sv =====
// ----------------------------------------------------------------------------
// sbd_queue: short queue of pair entries
// Decouples the intake from the filter pipeline.
// ----------------------------------------------------------------------------
module sbd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbd_pkg::entry_type  push_entry,
   input  logic                pop,
   output sbd_pkg::entry_type  pop_entry,
   output logic                empty,
   output logic                full
);

   sbd_pkg::entry_type slot_ff [sbd_pkg::QueueDepth];

   logic [sbd_pkg::QueuePtrBits-1:0]   wr_ptr_ff;
   logic [sbd_pkg::QueuePtrBits-1:0]   wr_ptr_in;
   logic [sbd_pkg::QueuePtrBits-1:0]   rd_ptr_ff;
   logic [sbd_pkg::QueuePtrBits-1:0]   rd_ptr_in;
   logic [sbd_pkg::QueueCountBits-1:0] count_ff;
   logic [sbd_pkg::QueueCountBits-1:0] count_in;

   localparam logic [sbd_pkg::QueuePtrBits-1:0] LastSlot =
      sbd_pkg::QueuePtrBits'(sbd_pkg::QueueDepth - 1);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry = slot_ff[rd_ptr_ff];
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == sbd_pkg::QueueCountBits'(sbd_pkg::QueueDepth));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not follow a push");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sbd_pkg::QueueCountBits'(sbd_pkg::QueueDepth))
      else $error("queue fill count beyond its depth");
`endif

endmodule

// ===== rtl/core/sbd_back.sv =====
// ----------------------------------------------------------------------------
// sbd_back: row combining and sRGB encode pipeline
// Keeps the pair sums of the even row in a RAM, adds them to the odd row and
// encodes the mean by an eight-step pipelined search over the thresholds.
// ----------------------------------------------------------------------------
module sbd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  sbd_pkg::entry_type  pop_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sbd_pkg::rsp_type    rsp_pixel
);

   typedef struct packed {
      sbd_pkg::kind_type                                    kind;
      logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::PairBits-1:0] pair_color;
      logic [sbd_pkg::AlphaPairBits-1:0]                     pair_alpha;
      logic                                                  color_mode;
      logic                                                  level_done;
   } pair_stage_type;

   typedef struct packed {
      logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::TotBits-1:0] tot_color;
      logic [sbd_pkg::AlphaTotBits-1:0]                     tot_alpha;
      logic                                                 color_mode;
      logic                                                 level_done;
   } sum_stage_type;

   typedef struct packed {
      logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::IndexBits-1:0] index;
      logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::ByteBits-1:0]  code;
      logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::ByteBits-1:0]  raw;
      logic [sbd_pkg::ByteBits-1:0]                           alpha;
      logic                                                   color_mode;
      logic                                                   level_done;
   } search_type;

   // One bit of the search: keep the candidate if its threshold is reached.
   function automatic search_type search_step(input search_type s, input int step);
      search_type                   r;
      logic [sbd_pkg::ByteBits-1:0] cand;
      r = s;
      for (int j = 0; j < sbd_pkg::ColorLanes; j++) begin
         cand = s.code[j] | (sbd_pkg::ByteBits'(1) << (sbd_pkg::SearchSteps - 1 - step));
         if (sbd_pkg::ThrTab[cand] <= sbd_pkg::ThrBits'({s.index[j], 1'b1})) begin
            r.code[j] = cand;
         end
      end
      return r;
   endfunction

   logic advance;
   logic ram_we;
   logic ram_re;
   logic [sbd_pkg::StoreBits-1:0] ram_wdata;
   logic [sbd_pkg::StoreBits-1:0] ram_rdata;
   logic [sbd_pkg::ColorLanes-1:0][sbd_pkg::PairBits-1:0] stored_color;
   logic [sbd_pkg::AlphaPairBits-1:0]                     stored_alpha;

   pair_stage_type s1_ff;
   logic           s1_valid_ff;
   sum_stage_type  s2_ff;
   sum_stage_type  s2_in;
   logic           s2_valid_ff;

   search_type                       srch_ff   [sbd_pkg::SearchSteps];
   search_type                       srch_next [sbd_pkg::SearchSteps];
   search_type                       srch_load;
   logic [sbd_pkg::SearchSteps-1:0]  srch_valid_ff;

   sbd_pkg::rsp_type rsp_ff;
   sbd_pkg::rsp_type rsp_in;
   logic             rsp_valid_ff;

   logic [sbd_pkg::TotBits:0]         raw_sum;
   logic [sbd_pkg::TotBits-2:0]       raw_mean;
   logic [sbd_pkg::AlphaTotBits:0]    alpha_sum;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !queue_empty;
   assign ram_we  = pop && (pop_entry.kind == sbd_pkg::KIND_STORE);
   assign ram_re  = pop && (pop_entry.kind == sbd_pkg::KIND_COMBINE);
   assign ram_wdata = {pop_entry.pair_color, pop_entry.pair_alpha};

   sbd_ram #(
      .Width (sbd_pkg::StoreBits),
      .Depth (sbd_pkg::StoreDepth)
   ) u_row_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (pop_entry.addr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (pop_entry.addr),
      .rdata (ram_rdata)
   );

   assign {stored_color, stored_alpha} = ram_rdata;

   always_comb begin
      s2_in.color_mode = s1_ff.color_mode;
      s2_in.level_done = s1_ff.level_done;
      unique case (s1_ff.kind)
         sbd_pkg::KIND_COMBINE: begin
            for (int j = 0; j < sbd_pkg::ColorLanes; j++) begin
               s2_in.tot_color[j] = sbd_pkg::TotBits'(stored_color[j])
                                  + sbd_pkg::TotBits'(s1_ff.pair_color[j]);
            end
            s2_in.tot_alpha = sbd_pkg::AlphaTotBits'(stored_alpha)
                            + sbd_pkg::AlphaTotBits'(s1_ff.pair_alpha);
         end
         default: begin
            for (int j = 0; j < sbd_pkg::ColorLanes; j++) begin
               s2_in.tot_color[j] = {s1_ff.pair_color[j], 1'b0};
            end
            s2_in.tot_alpha = {s1_ff.pair_alpha, 1'b0};
         end
      endcase
   end

   // Data-mode bytes are rounded here, the colour index is the mean's top bits.
   always_comb begin
      raw_sum   = '0;
      raw_mean  = '0;
      srch_load.color_mode = s2_ff.color_mode;
      srch_load.level_done = s2_ff.level_done;
      for (int j = 0; j < sbd_pkg::ColorLanes; j++) begin
         raw_sum  = (sbd_pkg::TotBits + 1)'(s2_ff.tot_color[j]) + 2'd2;
         raw_mean = raw_sum[sbd_pkg::TotBits:2];
         srch_load.raw[j]   = (raw_mean > (sbd_pkg::TotBits - 1)'(8'hFF))
                            ? {sbd_pkg::ByteBits{1'b1}} : raw_mean[sbd_pkg::ByteBits-1:0];
         srch_load.index[j] = s2_ff.tot_color[j][sbd_pkg::TotBits-1 -: sbd_pkg::IndexBits];
         srch_load.code[j]  = '0;
      end
      alpha_sum       = (sbd_pkg::AlphaTotBits + 1)'(s2_ff.tot_alpha) + 2'd2;
      srch_load.alpha = alpha_sum[sbd_pkg::ByteBits+1:2];
   end

   always_comb begin
      for (int m = 0; m < sbd_pkg::SearchSteps; m++) begin
         srch_next[m] = search_step(srch_ff[m], m);
      end
   end

   always_comb begin
      search_type last;
      last = srch_next[sbd_pkg::SearchSteps-1];
      rsp_in.red_out    = last.color_mode ? last.code[0] : last.raw[0];
      rsp_in.green_out  = last.color_mode ? last.code[1] : last.raw[1];
      rsp_in.blue_out   = last.color_mode ? last.code[2] : last.raw[2];
      rsp_in.alpha_out  = last.alpha;
      rsp_in.level_done = last.level_done;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.kind       <= pop_entry.kind;
         s1_ff.pair_color <= pop_entry.pair_color;
         s1_ff.pair_alpha <= pop_entry.pair_alpha;
         s1_ff.color_mode <= pop_entry.color_mode;
         s1_ff.level_done <= pop_entry.level_done;
         s2_ff            <= s2_in;
         srch_ff[0]       <= srch_load;
         for (int m = 1; m < sbd_pkg::SearchSteps; m++) begin
            srch_ff[m] <= srch_next[m-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         srch_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff   <= pop && (pop_entry.kind != sbd_pkg::KIND_STORE);
         s2_valid_ff   <= s1_valid_ff;
         srch_valid_ff <= {srch_valid_ff[sbd_pkg::SearchSteps-2:0], s2_valid_ff};
         rsp_valid_ff  <= srch_valid_ff[sbd_pkg::SearchSteps-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_ff;

`ifndef SYNTH
   a_read_feeds_combine: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> (s1_valid_ff && (s1_ff.kind == sbd_pkg::KIND_COMBINE)))
      else $error("row store read not followed by a combining stage");
`endif

endmodule

// ===== rtl/core/srgb_box_downsample_2x2_unit.sv =====
// ----------------------------------------------------------------------------
// srgb_box_downsample_2x2_unit: streaming sRGB-correct 2x2 mip level generator
// Result path: a queue slot, the row store read stage, the sum stage, eight
// search stages and the output register, which drives rsp_valid.
// Throughput: one source pixel per cycle while the queue is not full; the row
// store has one write and one read port, and each popped pair uses at most one.
// Reset (synchronous, active high): width 1, height 1, colour mode on, both
// counters and the queue cleared; the row store is not cleared.
// ----------------------------------------------------------------------------
module srgb_box_downsample_2x2_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sbd_pkg::req_type                    req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sbd_pkg::rsp_type                    rsp_pixel,
   input  logic                                csr_we,
   input  logic [sbd_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [sbd_pkg::CsrDataBits-1:0]     csr_wdata
);

   // Configuration registers. Sizes are clamped to their legal range as they
   // are written, so the rest of the design never sees a zero or an oversize.
   logic [sbd_pkg::WidthRegBits-1:0]  width_ff;
   logic [sbd_pkg::WidthRegBits-1:0]  width_in;
   logic [sbd_pkg::HeightRegBits-1:0] height_ff;
   logic [sbd_pkg::HeightRegBits-1:0] height_in;
   logic                              mode_ff;
   logic                              mode_in;
   logic [sbd_pkg::WidthRegBits-1:0]  new_width;
   logic [sbd_pkg::HeightRegBits-1:0] new_height;
   logic                              restart;

   sbd_pkg::cfg_type   cfg;
   sbd_pkg::entry_type push_entry;
   sbd_pkg::entry_type pop_entry;
   logic               push;
   logic               pop;
   logic               queue_empty;
   logic               queue_full;

   localparam logic [sbd_pkg::WidthRegBits-1:0] WidthLimit =
      sbd_pkg::WidthRegBits'(sbd_pkg::MaxWidth);
   localparam logic [sbd_pkg::HeightRegBits-1:0] HeightLimit =
      sbd_pkg::HeightRegBits'(sbd_pkg::MaxHeight);

   assign new_width  = csr_wdata[sbd_pkg::WidthRegBits-1:0];
   assign new_height = csr_wdata[sbd_pkg::HeightRegBits-1:0];

   // A write to either size restarts the level; a write to an index beyond
   // the register list is simply ignored.
   assign restart = csr_we && ((csr_index == sbd_pkg::CSR_WIDTH) ||
                               (csr_index == sbd_pkg::CSR_HEIGHT));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            sbd_pkg::CSR_WIDTH: begin
               width_in = (new_width == '0) ? sbd_pkg::WidthRegBits'(1)
                        : (new_width > WidthLimit) ? WidthLimit : new_width;
            end
            sbd_pkg::CSR_HEIGHT: begin
               height_in = (new_height == '0) ? sbd_pkg::HeightRegBits'(1)
                         : (new_height > HeightLimit) ? HeightLimit : new_height;
            end
            sbd_pkg::CSR_MODE: begin
               mode_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sbd_pkg::WidthRegBits'(1);
         height_ff <= sbd_pkg::HeightRegBits'(1);
         mode_ff   <= 1'b1;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
      end
   end

   always_comb begin
      cfg.width      = width_ff;
      cfg.height     = height_ff;
      cfg.color_mode = mode_ff;
      cfg.restart    = restart;
   end

   // The front end takes one transaction per cycle unless the queue is full.
   // Each pixel is converted with the mode in force at its arrival; every
   // second pixel of a row completes a horizontal pair, which is queued with
   // the action for its row: store it, double it, or add it to the row above.
   sbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // The queue lets the intake keep running for a few pairs while the result
   // side is held up.
   sbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // The back end is one pipeline that moves as a whole whenever its output
   // register is free or being taken. Stored rows sit in the row store RAM.
   sbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel   (rsp_pixel)
   );

endmodule

// ===== tb/sv/sbd_mip_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbd_mip_checker: scoreboard for the sRGB 2x2 box downsampler
// Tracks register writes and accepted source pixels through an independent
// model of the mip filter, and compares each downsampled pixel in order.
// ----------------------------------------------------------------------------
module sbd_mip_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  sbd_pkg::req_type                 req_pixel,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  sbd_pkg::rsp_type                 rsp_pixel,
   input  logic                             csr_we,
   input  logic [sbd_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [sbd_pkg::CsrDataBits-1:0]  csr_wdata,
   output int                               error_count,
   output int                               awaited,
   output int                               checked
);
   import sbd_pkg::*;

   localparam longint unsigned Q30One = 64'd1 << 30;

   typedef struct packed {
      bit [ColorLanes-1:0][LinBits-1:0] lane;
      bit [ByteBits-1:0]                alpha;
   } lin_pixel_t;

   typedef struct packed {
      bit [ColorLanes-1:0][PairBits-1:0] lane;
      bit [AlphaPairBits-1:0]            alpha;
   } pair_sum_t;

   bit [LinBits-1:0]       linear_of_srgb [TabDepth];
   bit [ByteBits-1:0]      srgb_of_linear [1 << IndexBits];

   bit [WidthRegBits-1:0]  width_reg;
   bit [HeightRegBits-1:0] height_reg;
   bit                     srgb_on;
   int unsigned            col_pos;
   int unsigned            row_pos;
   lin_pixel_t             left_pixel;
   pair_sum_t              upper_pairs [StoreDepth];
   rsp_type                expected_mip_q [$];
   int                     mismatch_total = 0;
   int                     result_total = 0;

   function automatic longint unsigned fix_mul(input longint unsigned x,
                                               input longint unsigned y);
      return (x * y) >> 30;
   endfunction

   // Largest Q30 value whose truncated fifth power does not exceed v.
   function automatic longint unsigned fifth_root(input longint unsigned v);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned z2;
      lo = 0;
      hi = Q30One;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         z2  = fix_mul(mid, mid);
         if (fix_mul(fix_mul(z2, z2), mid) <= v) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo;
   endfunction

   // sRGB decode of num/den into linear light, Q30.
   function automatic longint unsigned srgb_to_light(input longint unsigned num,
                                                     input longint unsigned den);
      longint unsigned y;
      longint unsigned y2;
      if (num * 100000 <= 4045 * den) begin
         return ((num << 30) * 100) / (den * 1292);
      end
      y = ((1000 * num + 55 * den) << 30) / (1055 * den);
      if (y > Q30One) begin
         y = Q30One;
      end
      y2 = fix_mul(y, y);
      return fix_mul(y2, fifth_root(y2));
   endfunction

   initial begin : build_tables
      longint unsigned level_of [TabDepth];
      longint unsigned v;
      longint unsigned step;
      int              b;
      for (int c = 0; c < TabDepth; c++) begin
         v = (srgb_to_light(64'(c), 64'd255) + 8192) >> 14;
         linear_of_srgb[c] = (v > 65535) ? {LinBits{1'b1}} : LinBits'(v);
      end
      // Decision level of byte b sits half a code below it.
      level_of[0] = 0;
      for (int c = 1; c < TabDepth; c++) begin
         level_of[c] = srgb_to_light(64'(2 * c - 1), 64'd510);
      end
      b = 1;
      for (int i = 0; i < (1 << IndexBits); i++) begin
         step = 64'(2 * i + 1);
         step = step << 17;
         while (b < TabDepth && level_of[b] <= step) begin
            b++;
         end
         srgb_of_linear[i] = ByteBits'(b - 1);
      end
   end

   function automatic int unsigned fit_side(input int unsigned v,
                                            input int unsigned ceiling);
      if (v < 1) begin
         return 1;
      end
      return (v > ceiling) ? ceiling : v;
   endfunction

   // Advances the filter by one source pixel; returns 1 when a mip pixel results.
   function automatic bit predict_mip_pixel(input req_type px,
                                            output rsp_type mip);
      int unsigned       w, h, nw, nh, col, row, k, orow, v;
      int unsigned       conv [ColorLanes];
      int unsigned       pair_c [ColorLanes];
      int unsigned       sum_c [ColorLanes];
      int unsigned       outv [ColorLanes];
      int unsigned       conv_a, pair_a, sum_a;
      bit [ByteBits-1:0] src [ColorLanes];
      bit                paired;
      bit                emit;
      w   = fit_side(32'(width_reg), MaxWidth);
      h   = fit_side(32'(height_reg), MaxHeight);
      nw  = (w > 1) ? w / 2 : 1;
      nh  = (h > 1) ? h / 2 : 1;
      col = col_pos;
      row = row_pos;
      k   = (col >> 1) % StoreDepth;
      mip = '0;
      src[0] = px.red_in;
      src[1] = px.green_in;
      src[2] = px.blue_in;
      for (int j = 0; j < ColorLanes; j++) begin
         conv[j] = srgb_on ? 32'(linear_of_srgb[src[j]]) : 32'(src[j]);
      end
      conv_a = 32'(px.alpha_in);
      paired = 1'b0;
      emit   = 1'b0;

      // Horizontal pairing: a one pixel wide level uses each pixel twice.
      if (w == 1) begin
         for (int j = 0; j < ColorLanes; j++) begin
            pair_c[j] = 2 * conv[j];
         end
         pair_a = 2 * conv_a;
         paired = 1'b1;
      end else if (col % 2 == 0) begin
         if (col + 1 < w) begin
            for (int j = 0; j < ColorLanes; j++) begin
               left_pixel.lane[j] = LinBits'(conv[j]);
            end
            left_pixel.alpha = ByteBits'(conv_a);
         end
      end else begin
         for (int j = 0; j < ColorLanes; j++) begin
            pair_c[j] = left_pixel.lane[j] + conv[j];
         end
         pair_a = left_pixel.alpha + conv_a;
         paired = 1'b1;
      end

      // Vertical pairing through the row store.
      if (paired) begin
         if (h == 1) begin
            for (int j = 0; j < ColorLanes; j++) begin
               sum_c[j] = 2 * pair_c[j];
            end
            sum_a = 2 * pair_a;
            emit  = 1'b1;
         end else if (row % 2 == 0) begin
            if (row + 1 < h) begin
               for (int j = 0; j < ColorLanes; j++) begin
                  upper_pairs[k].lane[j] = PairBits'(pair_c[j]);
               end
               upper_pairs[k].alpha = AlphaPairBits'(pair_a);
            end
         end else begin
            for (int j = 0; j < ColorLanes; j++) begin
               sum_c[j] = upper_pairs[k].lane[j] + pair_c[j];
            end
            sum_a = upper_pairs[k].alpha + pair_a;
            emit  = 1'b1;
         end
      end

      if (emit) begin
         orow = (h == 1) ? 0 : row >> 1;
         for (int j = 0; j < ColorLanes; j++) begin
            if (srgb_on) begin
               outv[j] = srgb_of_linear[(sum_c[j] >> 6) & 4095];
            end else begin
               v = (sum_c[j] + 2) >> 2;
               outv[j] = (v > 255) ? 255 : v;
            end
         end
         mip.red_out    = ByteBits'(outv[0]);
         mip.green_out  = ByteBits'(outv[1]);
         mip.blue_out   = ByteBits'(outv[2]);
         mip.alpha_out  = ByteBits'((sum_a + 2) >> 2);
         mip.level_done = (orow == nh - 1) && ((col >> 1) == nw - 1);
      end

      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) begin
            row = 0;
         end
      end
      col_pos = col;
      row_pos = row;
      return emit;
   endfunction

   function automatic int field_differs(input string name,
                                        input logic [ByteBits-1:0] want_v,
                                        input logic [ByteBits-1:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (reset) begin
         width_reg  = WidthRegBits'(1);
         height_reg = HeightRegBits'(1);
         srgb_on    = 1'b1;
         col_pos    = 0;
         row_pos    = 0;
         left_pixel = '0;
         expected_mip_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_WIDTH: begin
                  width_reg = csr_wdata[WidthRegBits-1:0];
                  col_pos   = 0;
                  row_pos   = 0;
               end
               CSR_HEIGHT: begin
                  height_reg = csr_wdata[HeightRegBits-1:0];
                  col_pos    = 0;
                  row_pos    = 0;
               end
               CSR_MODE: begin
                  srgb_on = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            if (predict_mip_pixel(req_pixel, want)) begin
               expected_mip_q.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_mip_q.size() == 0) begin
               $error("downsampled pixel arrived with none expected: %p", rsp_pixel);
               mismatch_total++;
            end else begin
               want = expected_mip_q.pop_front();
               result_total++;
               mismatch_total += field_differs("red_out", want.red_out,
                                               rsp_pixel.red_out);
               mismatch_total += field_differs("green_out", want.green_out,
                                               rsp_pixel.green_out);
               mismatch_total += field_differs("blue_out", want.blue_out,
                                               rsp_pixel.blue_out);
               mismatch_total += field_differs("alpha_out", want.alpha_out,
                                               rsp_pixel.alpha_out);
               mismatch_total += field_differs("level_done",
                                               ByteBits'(want.level_done),
                                               ByteBits'(rsp_pixel.level_done));
            end
         end
      end
      error_count <= mismatch_total;
      awaited     <= expected_mip_q.size();
      checked     <= result_total;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sRGB 2x2 box downsampler
// Drives source pixels in bursts and reprograms level size and colour mode
// between levels, while the checker beside the block predicts and compares
// every downsampled pixel.
// ----------------------------------------------------------------------------
module tb_top;
   import sbd_pkg::*;

   // Settle time that outlasts the block's path from acceptance to result.
   localparam int SettleCycles  = 24;
   localparam int RandomTarget  = 600;
   localparam int HoldOffCycles = 200;
   // An index that selects no register at all; writes to it must be ignored.
   localparam logic [CsrIndexBits-1:0] CsrSpare = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_pixel;
   logic                    csr_we = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0]  csr_wdata = '0;

   int error_count;
   int awaited;
   int checked;

   // Sender state: the length of the current burst, and whether gaps are off.
   int burst_left = 0;
   bit steady = 1'b0;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit squeeze = 1'b0;
   int pixels_sent = 0;
   int settings_used = 0;

   always #5 clock = ~clock;

   srgb_box_downsample_2x2_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_pixel (rsp_pixel),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sbd_mip_checker mip_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel   (req_pixel),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel   (rsp_pixel),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .awaited     (awaited),
      .checked     (checked)
   );

   function automatic req_type rgba(input logic [ByteBits-1:0] r,
                                    input logic [ByteBits-1:0] g,
                                    input logic [ByteBits-1:0] b,
                                    input logic [ByteBits-1:0] a);
      req_type px;
      px.red_in   = r;
      px.green_in = g;
      px.blue_in  = b;
      px.alpha_in = a;
      return px;
   endfunction

   // Bytes lean towards the two ends of the range, where rounding is tightest.
   function automatic logic [ByteBits-1:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return ByteBits'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type any_pixel();
      return rgba(pick_byte(), pick_byte(), pick_byte(), pick_byte());
   endfunction

   // The mode register only looks at bit 0, so the rest of the word is noise.
   function automatic logic [CsrDataBits-1:0] mode_word(input bit srgb);
      logic [CsrDataBits-2:0] junk;
      junk = (CsrDataBits - 1)'($urandom);
      return {junk, srgb};
   endfunction

   // Effective side length after masking to the register width and clamping.
   function automatic int unsigned side_of(input int unsigned word,
                                           input int unsigned bits,
                                           input int unsigned ceiling);
      int unsigned v;
      v = word & ((1 << bits) - 1);
      if (v == 0) begin
         return 1;
      end
      return (v > ceiling) ? ceiling : v;
   endfunction

   // Holds the write enable high; the caller lowers it after the last write,
   // so that back-to-back writes never drive it twice in one time step.
   task automatic csr_put(input logic [CsrIndexBits-1:0] idx,
                          input logic [CsrDataBits-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_level(input int unsigned w_word, input int unsigned h_word,
                            input bit srgb);
      csr_put(CSR_WIDTH, CsrDataBits'(w_word));
      csr_put(CSR_HEIGHT, CsrDataBits'(h_word));
      csr_put(CSR_MODE, mode_word(srgb));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Offers one pixel and waits for its transaction. Bursts of random length
   // are separated by gaps of random length unless the sender is steady.
   task automatic push_pixel(input req_type px);
      int gap;
      req_pixel <= px;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pixels_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Brings the block to rest: every predicted pixel has come out, and enough
   // cycles have passed for pixels that produce nothing to leave the pipeline.
   // The first edge lets the checker's count include the last transaction.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One level setting with random content. A split flips the colour mode
   // half way through, so that squares straddle the change.
   task automatic run_level(input int unsigned w_word, input int unsigned h_word,
                            input bit srgb, input int unsigned count,
                            input bit split);
      set_level(w_word, h_word, srgb);
      for (int i = 0; i < count; i++) begin
         if (split && i == count / 2) begin
            drain();
            csr_put(CSR_MODE, mode_word(!srgb));
            csr_we <= 1'b0;
         end
         push_pixel(any_pixel());
      end
      drain();
   endtask

   // Receiver: spans of free flow, light, medium and heavy stalling, and one
   // long hold-off on request while the sender keeps going.
   initial begin : receiver
      int span;
      int style;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (squeeze) begin
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            squeeze = 1'b0;
         end else begin
            span  = $urandom_range(8, 40);
            style = $urandom_range(0, 3);
            repeat (span) begin
               case (style)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= ($urandom_range(0, 1) == 0);
                  default: rsp_stall <= ($urandom_range(0, 4) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned w_word;
      int unsigned h_word;
      int unsigned level_px;
      int unsigned count;
      int          random_from;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset values give a one by one level: each pixel is its own output,
      // and both ends of the byte range pass through the colour tables.
      push_pixel(rgba(8'h00, 8'h00, 8'h00, 8'h00));
      push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      drain();

      // A 2x2 level in colour mode with mixed extremes. A write to an unused
      // register index goes first and must change nothing.
      csr_put(CsrSpare, '1);
      set_level(2, 2, 1'b1);
      push_pixel(rgba(8'hFF, 8'h00, 8'h80, 8'h00));
      push_pixel(rgba(8'h00, 8'hFF, 8'h01, 8'hFF));
      push_pixel(rgba(8'h80, 8'h01, 8'hFF, 8'h00));
      push_pixel(rgba(8'h01, 8'h80, 8'h00, 8'hFF));
      drain();

      // Odd width and height in data mode: the last column and row are dropped.
      set_level(3, 3, 1'b0);
      for (int i = 0; i < 9; i++) begin
         push_pixel(rgba((i % 2 == 1) ? 8'hFF : 8'h00, (i % 3 == 0) ? 8'hFF : 8'h00,
                         ByteBits'(i * 31), (i > 4) ? 8'hFF : 8'h00));
      end
      drain();

      // A width of zero clamps to one, so each row's pixel is used twice.
      set_level(0, 2, 1'b0);
      push_pixel(rgba(8'hFF, 8'hFF, 8'h00, 8'h01));
      push_pixel(rgba(8'h00, 8'hFE, 8'hFF, 8'hFF));
      drain();

      // Mode change inside a square: the top row is stored as linear light,
      // the bottom row arrives as raw bytes and the data-mode sum saturates.
      set_level(2, 2, 1'b1);
      push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      push_pixel(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      drain();
      csr_put(CSR_MODE, mode_word(1'b0));
      csr_we <= 1'b0;
      push_pixel(rgba(8'hFF, 8'h00, 8'hFF, 8'h00));
      push_pixel(rgba(8'hFF, 8'hFF, 8'h00, 8'h00));
      drain();

      random_from = pixels_sent;

      // Back-pressure: a long hold-off on the result side while a steady
      // stream keeps coming, so that the queue fills and the input stalls.
      squeeze = 1'b1;
      steady  = 1'b1;
      run_level(6, 24, 1'b1, 144, 1'b0);

      // Register extremes. Oversized words are masked and clamped, and the
      // largest levels are only started, never finished.
      steady = 1'b0;
      run_level('h7FFF, 1, 1'($urandom_range(0, 1)), 40, 1'b0);
      run_level(1, 'h7FFF, 1'($urandom_range(0, 1)), 40, 1'b1);
      run_level(0, 0, 1'($urandom_range(0, 1)), 3, 1'b0);
      run_level(MaxWidth, 2, 1'($urandom_range(0, 1)), 48, 1'b0);
      run_level(2, MaxHeight, 1'($urandom_range(0, 1)), 24, 1'b0);

      // Mostly small complete levels with random content; some are cut short
      // and some run on into the start of the next level.
      while (pixels_sent - random_from < RandomTarget) begin
         case ($urandom_range(0, 19))
            0:       w_word = 0;
            1:       w_word = MaxWidth;
            2:       w_word = 'h7FFF;
            3:       w_word = MaxWidth + 1 + $urandom_range(0, 100);
            default: w_word = $urandom_range(1, 10);
         endcase
         case ($urandom_range(0, 19))
            0:       h_word = 0;
            1:       h_word = MaxHeight;
            2:       h_word = 'h7FFF;
            3:       h_word = MaxHeight + 1 + $urandom_range(0, 100);
            default: h_word = $urandom_range(1, 8);
         endcase
         level_px = side_of(w_word, WidthRegBits, MaxWidth) *
                    side_of(h_word, HeightRegBits, MaxHeight);
         if (level_px > 160) begin
            count = $urandom_range(24, 96);
         end else begin
            case ($urandom_range(0, 5))
               0:       count = $urandom_range(1, level_px);
               1:       count = level_px + $urandom_range(1, level_px);
               default: count = level_px;
            endcase
         end
         steady = ($urandom_range(0, 3) == 0);
         run_level(w_word, h_word, 1'($urandom_range(0, 1)), count,
                   $urandom_range(0, 3) == 0);
      end

      $display("Run covered %0d source pixels over %0d level settings;", pixels_sent,
               settings_used);
      $display("%0d downsampled pixels were compared.", checked);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin : watchdog
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
